// ----- rtl/xfr_pkg.sv -----
`timescale 1ns / 1ps

package xfr_pkg;

	// Default buffer depth of one frame bank
	localparam int unsigned FRAME_DEPTH_DEF = 256;

	// Protocol bytes
	localparam logic [7:0] HDR_FIRST  = 8'h3A;
	localparam logic [7:0] HDR_SECOND = 8'h5C;
	localparam logic [7:0] LINK_REQ   = 8'h66;
	localparam logic [7:0] LINK_ACK   = 8'h99;

	// Request kinds carried in s_tuser
	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Parser phases
	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HDR2 = 2'd1,
		PH_LEN  = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	// Frame event codes
	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_ACCEPT   = 2'd1,
		EV_BAD_SUM  = 2'd2,
		EV_ZERO_LEN = 2'd3
	} frame_ev_t;

	// Parser status after one request
	typedef struct packed {
		logic       reply;
		frame_ev_t  ev;
		logic       linked;
		phase_t     phase;
		logic [7:0] clen;
		logic       bank;
	} par_res_t;

	// Buffer write port
	typedef struct packed {
		logic       en;
		logic       bank;
		logic [7:0] idx;
		logic [7:0] data;
	} mem_wr_t;

endpackage

// ----- rtl/xfr_parser.sv -----
`timescale 1ns / 1ps

module xfr_parser #(
	parameter int unsigned FRAME_DEPTH = xfr_pkg::FRAME_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        rx_byte,
	output xfr_pkg::par_res_t res,
	output xfr_pkg::mem_wr_t  wr
);

	logic             link_q, link_d;
	xfr_pkg::phase_t  phase_q, phase_d;
	logic [7:0]       exp_len_q, exp_len_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [7:0]       xor_q, xor_d;
	logic             bank_q, bank_d;
	logic [7:0]       clen_q, clen_d;
	logic             in_body;
	logic             sum_ok;
	logic             store_ok;

	assign in_body  = cnt_q < exp_len_q;
	assign sum_ok   = xor_q == rx_byte;
	assign store_ok = {1'b0, cnt_q} < 9'(FRAME_DEPTH);

	// Next state
	always_comb begin
		link_d    = link_q;
		phase_d   = phase_q;
		exp_len_d = exp_len_q;
		cnt_d     = cnt_q;
		xor_d     = xor_q;
		bank_d    = bank_q;
		clen_d    = clen_q;
		if (en && !link_q) begin
			if (rx_byte == xfr_pkg::LINK_REQ) begin
				link_d = 1'b1;
			end
		end else if (en) begin
			unique case (phase_q)
				xfr_pkg::PH_HUNT: begin
					if (rx_byte == xfr_pkg::HDR_FIRST) begin
						phase_d = xfr_pkg::PH_HDR2;
					end
				end
				xfr_pkg::PH_HDR2: begin
					phase_d = (rx_byte == xfr_pkg::HDR_SECOND) ? xfr_pkg::PH_LEN
						: xfr_pkg::PH_HUNT;
				end
				xfr_pkg::PH_LEN: begin
					cnt_d = 8'd0;
					xor_d = 8'd0;
					if (rx_byte == 8'd0) begin
						exp_len_d = 8'd0;
						phase_d   = xfr_pkg::PH_HUNT;
					end else begin
						exp_len_d = rx_byte;
						phase_d   = xfr_pkg::PH_BODY;
					end
				end
				xfr_pkg::PH_BODY: begin
					if (in_body) begin
						xor_d = xor_q ^ rx_byte;
						cnt_d = cnt_q + 8'd1;
					end else begin
						if (sum_ok) begin
							bank_d = ~bank_q;
							clen_d = exp_len_q;
						end
						phase_d   = xfr_pkg::PH_HUNT;
						exp_len_d = 8'd0;
						cnt_d     = 8'd0;
						xor_d     = 8'd0;
					end
				end
				default: phase_d = xfr_pkg::PH_HUNT;
			endcase
		end
	end

	// Outputs: link reply, frame event and buffer write
	always_comb begin
		res.reply  = 1'b0;
		res.ev     = xfr_pkg::EV_NONE;
		res.linked = link_d;
		res.phase  = phase_d;
		res.clen   = clen_d;
		res.bank   = bank_q;
		wr.en      = 1'b0;
		wr.bank    = ~bank_q;
		wr.idx     = cnt_q;
		wr.data    = rx_byte;
		if (en && !link_q) begin
			res.reply = rx_byte == xfr_pkg::LINK_REQ;
		end else if (en) begin
			unique case (phase_q)
				xfr_pkg::PH_LEN: begin
					if (rx_byte == 8'd0) begin
						res.ev = xfr_pkg::EV_ZERO_LEN;
					end
				end
				xfr_pkg::PH_BODY: begin
					if (in_body) begin
						wr.en = store_ok;
					end else begin
						res.ev = sum_ok ? xfr_pkg::EV_ACCEPT : xfr_pkg::EV_BAD_SUM;
					end
				end
				default: res.ev = xfr_pkg::EV_NONE;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q    <= 1'b0;
			phase_q   <= xfr_pkg::PH_HUNT;
			exp_len_q <= 8'd0;
			cnt_q     <= 8'd0;
			xor_q     <= 8'd0;
			bank_q    <= 1'b0;
			clen_q    <= 8'd0;
		end else begin
			link_q    <= link_d;
			phase_q   <= phase_d;
			exp_len_q <= exp_len_d;
			cnt_q     <= cnt_d;
			xor_q     <= xor_d;
			bank_q    <= bank_d;
			clen_q    <= clen_d;
		end
	end

endmodule

// ----- rtl/xfr_frame_ram.sv -----
`timescale 1ns / 1ps

module xfr_frame_ram #(
	parameter int unsigned FRAME_DEPTH = xfr_pkg::FRAME_DEPTH_DEF
) (
	input  logic             clk,
	input  xfr_pkg::mem_wr_t wr,
	input  logic             rd_en,
	input  logic             rd_bank,
	input  logic [7:0]       rd_idx,
	output logic [7:0]       rd_data
);

	localparam int unsigned IDX_W  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int unsigned DEPTH  = 2 * FRAME_DEPTH;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	// Bank one sits above bank zero
	assign wr_addr = wr.bank ? ADDR_W'(FRAME_DEPTH) + ADDR_W'(wr.idx[IDX_W-1:0])
		: ADDR_W'(wr.idx[IDX_W-1:0]);
	assign rd_addr = rd_bank ? ADDR_W'(FRAME_DEPTH) + ADDR_W'(rd_idx[IDX_W-1:0])
		: ADDR_W'(rd_idx[IDX_W-1:0]);

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
	end

	// Registered read port, holds while idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/xor_frame_receiver_core.sv -----
`timescale 1ns / 1ps

// Frame receiver with link handshake.
// Slave channel: one request per beat. s_tuser selects the kind: a received
// serial byte (rx_byte) or a read of one byte of the committed frame
// (read_index). Master channel: exactly one result per request, in order,
// carrying link reply, frame event, committed length, read data, link flag
// and parser phase.
// A result passes through the buffer read register, then the output register,
// before it shows on m_tvalid.
// One request per cycle while m_tready does not stall the output, set by the
// single write and read ports of the frame buffer; parser state is registered.
// Received payload bytes go straight into the fill bank, so a read never
// overlaps a pending write to the same entry.
// Reset clears link, parser, bank select and committed length; buffer
// contents stay undefined until written.
// When m_tready is low the output register and the buffer read stage hold;
// s_tready drops once both are full and rises in the cycle the output
// is taken.
module xor_frame_receiver_core #(
	parameter int unsigned FRAME_DEPTH = xfr_pkg::FRAME_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte[7:0], read_index[15:8]
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// reply_valid[0], reply_byte[8:1], frame_event[10:9],
	// committed_length[18:11], read_data[26:19], linked[27],
	// parse_phase[29:28], zero[31:30]
	output logic [31:0] m_tdata
);

	logic              s_acc;
	logic              rx_en;
	logic              rd_en;
	logic              adv_s1;
	logic              rd_oob;
	logic [7:0]        rd_data;
	logic [7:0]        read_data;
	xfr_pkg::par_res_t res;
	xfr_pkg::mem_wr_t  wr;

	logic              valid_s1;
	logic              cmd_s1;
	logic              oob_s1;
	xfr_pkg::par_res_t res_s1;

	logic              out_valid_q;
	logic [31:0]       out_data_q;

	// Handshake
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_acc    = s_tvalid && s_tready;
	assign rx_en    = s_acc && (s_tuser == xfr_pkg::CMD_RX);
	assign rd_en    = s_acc && (s_tuser == xfr_pkg::CMD_READ);
	assign rd_oob   = {1'b0, s_tdata[15:8]} >= 9'(FRAME_DEPTH);

	xfr_parser #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (rx_en),
		.rx_byte(s_tdata[7:0]),
		.res    (res),
		.wr     (wr)
	);

	xfr_frame_ram #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr     (wr),
		.rd_en  (rd_en),
		.rd_bank(res.bank),
		.rd_idx (s_tdata[15:8]),
		.rd_data(rd_data)
	);

	// Stage 1: parser status alongside buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1 <= s_tuser;
			oob_s1 <= rd_oob;
			res_s1 <= res;
		end
	end

	assign read_data = (cmd_s1 == xfr_pkg::CMD_READ && !oob_s1) ? rd_data : 8'd0;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {2'b00, res_s1.phase, res_s1.linked, read_data, res_s1.clen,
				res_s1.ev, res_s1.reply ? xfr_pkg::LINK_ACK : 8'd0, res_s1.reply};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Full pipe with a stalled receiver must refuse requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("request taken while pipe is full");

	// A link reply only comes with the link set and no frame event
	a_reply_linked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1.reply) |-> (res_s1.linked && res_s1.ev == xfr_pkg::EV_NONE))
		else $error("link reply without link");

	// Any frame event leaves the parser hunting
	a_event_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1.ev != xfr_pkg::EV_NONE) |-> (res_s1.phase == xfr_pkg::PH_HUNT))
		else $error("frame event with parser mid-frame");

	// Buffer writes never hit the committed bank
	a_fill_bank: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (wr.bank != res.bank))
		else $error("write into committed bank");

endmodule
